### rtl/core/ovrq_pkg.sv
// shared types and constants for the overwriting ring queue
// no dependencies; imported by the controller, datapath and top level
package ovrq_pkg;

  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 5;
  localparam int MODE_BITS  = 2;
  localparam int DEPTH_DEF  = 16;
  localparam int CAP_RESET  = 16;

  // request codes carried on in_mode
  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD   = 2'd0,
    MODE_POP   = 2'd1,
    MODE_FIND  = 2'd2,
    MODE_PURGE = 2'd3
  } mode_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic add;
    logic pop_fail;
    logic pop_issue;
    logic pop_finish;
    logic scan_start;
    logic scan_step;
    logic scan_finish;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic scan_done;
  } dp_sts_t;

endpackage

### rtl/core/overwriting_ring_queue_top.sv
// top level of the overwriting ring queue of signed words
// depends on ovrq_pkg, ovrq_ctrl and ovrq_datapath
//
// usage:
//   a request beat (in_mode, in_value) is taken at a clock edge where start is
//   high and busy is low. every request gives exactly one result beat on the
//   out_ ports, marked by out_strobe for one cycle; the receiver cannot stall,
//   so the beat must be captured in that cycle.
//   add: result beat in the cycle after the request, busy stays low, so adds
//     may follow one another every cycle.
//   remove oldest: one memory read of the head word; no read if the queue is empty.
//   contains / remove matching: the scan reads one ring entry per cycle
//     through the single memory read port and compacts the survivors
//     through the write port behind it.
//   cfg_wr_en writes the capacity (zero acts as one, above DEPTH acts as DEPTH)
//   and empties the queue; write it only while the block is idle.
//   reset (rst_n low, synchronous) empties the queue and sets capacity to
//   16, or DEPTH if smaller. ring contents are not cleared.
module overwriting_ring_queue_top #(
  parameter int DEPTH = ovrq_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ovrq_pkg::MODE_BITS-1:0]        in_mode,
  input  logic signed [ovrq_pkg::WORD_BITS-1:0] in_value,
  output logic                                  out_strobe,
  output logic signed [ovrq_pkg::WORD_BITS-1:0] out_result_value,
  output logic                                  out_success,
  output logic                                  out_overwrote,
  output logic [ovrq_pkg::COUNT_BITS-1:0]       out_fill_count,
  input  logic                                  cfg_wr_en,
  input  logic [ovrq_pkg::COUNT_BITS-1:0]       cfg_wr_data
);
  import ovrq_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // request sequencer
  ovrq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  // storage and scan datapath
  ovrq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_strobe       (out_strobe),
    .out_result_value (out_result_value),
    .out_success      (out_success),
    .out_overwrote    (out_overwrote),
    .out_fill_count   (out_fill_count)
  );

endmodule

### rtl/core/ovrq_datapath.sv
// ring storage, pointers, fill count, scan/compaction engine and result registers
// depends on ovrq_pkg; driven by commands from ovrq_ctrl
module ovrq_datapath #(
  parameter int DEPTH = ovrq_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ovrq_pkg::ctrl_cmd_t                   cmd_i,
  output ovrq_pkg::dp_sts_t                     sts_o,
  input  logic [ovrq_pkg::MODE_BITS-1:0]        in_mode,
  input  logic signed [ovrq_pkg::WORD_BITS-1:0] in_value,
  input  logic                                  cfg_wr_en,
  input  logic [ovrq_pkg::COUNT_BITS-1:0]       cfg_wr_data,
  output logic                                  out_strobe,
  output logic signed [ovrq_pkg::WORD_BITS-1:0] out_result_value,
  output logic                                  out_success,
  output logic                                  out_overwrote,
  output logic [ovrq_pkg::COUNT_BITS-1:0]       out_fill_count
);
  import ovrq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((IDX_W > COUNT_BITS) ? IDX_W : COUNT_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] CAP_INIT =
    (DEPTH < CAP_RESET) ? COUNT_BITS'(DEPTH) : COUNT_BITS'(CAP_RESET);

  // step one place around the ring, wrapping at the capacity
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                  input logic [COUNT_BITS-1:0] cap);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(idx) + CMP_W'(1);
    return (inc >= CMP_W'(cap)) ? '0 : inc[IDX_W-1:0];
  endfunction

  // ring memory
  logic [WORD_BITS-1:0] ring_mem [DEPTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] rd_data_r;

  // queue state
  logic [COUNT_BITS-1:0] cap_r, cap_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  // scan engine
  logic                  is_purge_r, is_purge_nxt;
  logic [WORD_BITS-1:0]  value_r, value_nxt;
  logic [IDX_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [COUNT_BITS-1:0] rd_left_r, rd_left_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]      last_wr_r, last_wr_nxt;
  logic [COUNT_BITS-1:0] kept_r, kept_nxt;
  logic                  found_r, found_nxt;

  // result beat
  logic                  out_strobe_r, out_strobe_nxt;
  logic [WORD_BITS-1:0]  out_value_r, out_value_nxt;
  logic                  out_success_r, out_success_nxt;
  logic                  out_overwrote_r, out_overwrote_nxt;
  logic [COUNT_BITS-1:0] out_fill_r, out_fill_nxt;

  logic [COUNT_BITS-1:0] cap_clamp;

  // clamp the written capacity into one..DEPTH
  always_comb begin
    cap_clamp = (cfg_wr_data == '0) ? COUNT_BITS'(1) : cfg_wr_data;
    if (32'(cap_clamp) > 32'(DEPTH)) begin
      cap_clamp = COUNT_BITS'(DEPTH);
    end
  end

  // next-state logic for all commands
  always_comb begin
    cap_nxt           = cap_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    is_purge_nxt      = is_purge_r;
    value_nxt         = value_r;
    rd_ptr_nxt        = rd_ptr_r;
    rd_left_nxt       = rd_left_r;
    cmp_vld_nxt       = cmp_vld_r;
    wr_ptr_nxt        = wr_ptr_r;
    last_wr_nxt       = last_wr_r;
    kept_nxt          = kept_r;
    found_nxt         = found_r;
    out_strobe_nxt    = 1'b0;
    out_value_nxt     = out_value_r;
    out_success_nxt   = out_success_r;
    out_overwrote_nxt = out_overwrote_r;
    out_fill_nxt      = out_fill_r;
    mem_we            = 1'b0;
    mem_waddr         = head_r;
    mem_wdata         = in_value;
    mem_re            = 1'b0;
    mem_raddr         = head_r;

    // add at the back, overwriting the oldest word when full
    if (cmd_i.add) begin
      mem_we            = 1'b1;
      out_strobe_nxt    = 1'b1;
      out_value_nxt     = in_value;
      out_success_nxt   = 1'b1;
      out_overwrote_nxt = 1'b0;
      if (count_r == '0) begin
        tail_nxt  = head_r;
        count_nxt = COUNT_BITS'(1);
      end else if (count_r >= cap_r) begin
        tail_nxt          = head_r;
        head_nxt          = ring_next(head_r, cap_r);
        out_overwrote_nxt = 1'b1;
      end else begin
        tail_nxt  = ring_next(tail_r, cap_r);
        mem_waddr = tail_nxt;
        count_nxt = count_r + COUNT_BITS'(1);
      end
      out_fill_nxt = count_nxt;
    end

    // pop on an empty queue
    if (cmd_i.pop_fail) begin
      out_strobe_nxt    = 1'b1;
      out_value_nxt     = '0;
      out_success_nxt   = 1'b0;
      out_overwrote_nxt = 1'b0;
      out_fill_nxt      = count_r;
    end

    // pop: read the head word
    if (cmd_i.pop_issue) begin
      mem_re    = 1'b1;
      mem_raddr = head_r;
    end

    // pop: return the word and retire the head
    if (cmd_i.pop_finish) begin
      count_nxt = count_r - COUNT_BITS'(1);
      if (count_r == COUNT_BITS'(1)) begin
        tail_nxt = head_r;
      end else begin
        head_nxt = ring_next(head_r, cap_r);
      end
      out_strobe_nxt    = 1'b1;
      out_value_nxt     = rd_data_r;
      out_success_nxt   = 1'b1;
      out_overwrote_nxt = 1'b0;
      out_fill_nxt      = count_nxt;
    end

    // search/compaction setup
    if (cmd_i.scan_start) begin
      is_purge_nxt = (mode_t'(in_mode) == MODE_PURGE);
      value_nxt    = in_value;
      rd_ptr_nxt   = head_r;
      rd_left_nxt  = count_r;
      cmp_vld_nxt  = 1'b0;
      wr_ptr_nxt   = head_r;
      last_wr_nxt  = head_r;
      kept_nxt     = '0;
      found_nxt    = 1'b0;
    end

    // one entry read and one entry compared per cycle
    if (cmd_i.scan_step) begin
      if (rd_left_r != '0) begin
        mem_re      = 1'b1;
        mem_raddr   = rd_ptr_r;
        rd_ptr_nxt  = ring_next(rd_ptr_r, cap_r);
        rd_left_nxt = rd_left_r - COUNT_BITS'(1);
        cmp_vld_nxt = 1'b1;
      end else begin
        cmp_vld_nxt = 1'b0;
      end
      if (cmp_vld_r) begin
        if (rd_data_r == value_r) begin
          found_nxt = 1'b1;
        end else if (is_purge_r) begin
          // survivor packs down behind the read pointer
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr_r;
          mem_wdata   = rd_data_r;
          last_wr_nxt = wr_ptr_r;
          wr_ptr_nxt  = ring_next(wr_ptr_r, cap_r);
          kept_nxt    = kept_r + COUNT_BITS'(1);
        end
      end
    end

    // search/compaction result
    if (cmd_i.scan_finish) begin
      out_strobe_nxt    = 1'b1;
      out_overwrote_nxt = 1'b0;
      if (is_purge_r) begin
        if (kept_r != count_r) begin
          count_nxt       = kept_r;
          tail_nxt        = (kept_r == '0) ? head_r : last_wr_r;
          out_value_nxt   = value_r;
          out_success_nxt = 1'b1;
        end else begin
          out_value_nxt   = '0;
          out_success_nxt = 1'b0;
        end
      end else begin
        out_value_nxt   = found_r ? value_r : '0;
        out_success_nxt = found_r;
      end
      out_fill_nxt = count_nxt;
    end

    // capacity write empties the queue
    if (cfg_wr_en) begin
      cap_nxt   = cap_clamp;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  // ring memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_INIT;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      rd_left_r    <= '0;
      cmp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      cap_r        <= cap_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      rd_left_r    <= rd_left_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    is_purge_r      <= is_purge_nxt;
    value_r         <= value_nxt;
    rd_ptr_r        <= rd_ptr_nxt;
    wr_ptr_r        <= wr_ptr_nxt;
    last_wr_r       <= last_wr_nxt;
    kept_r          <= kept_nxt;
    found_r         <= found_nxt;
    out_value_r     <= out_value_nxt;
    out_success_r   <= out_success_nxt;
    out_overwrote_r <= out_overwrote_nxt;
    out_fill_r      <= out_fill_nxt;
  end

  assign sts_o.empty     = (count_r == '0);
  assign sts_o.scan_done = (rd_left_r == '0) && !cmp_vld_r;

  assign out_strobe       = out_strobe_r;
  assign out_result_value = out_value_r;
  assign out_success      = out_success_r;
  assign out_overwrote    = out_overwrote_r;
  assign out_fill_count   = out_fill_r;

  // fill count never exceeds the capacity
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("fill count above capacity");

  // head stays inside the ring in use
  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(head_r) < CMP_W'(cap_r))
    else $error("head outside ring");

  // compaction never keeps more words than it read
  a_kept_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.scan_step |-> kept_r <= count_r)
    else $error("compaction kept too many words");

  // a pop that reads memory returns its beat after its ST_POP step
  a_pop_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pop_issue |-> ##2 out_strobe_r)
    else $error("pop result missing");

endmodule

### rtl/core/ovrq_ctrl.sv
// request sequencer for the overwriting ring queue
// depends on ovrq_pkg; issues commands to ovrq_datapath
module ovrq_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ovrq_pkg::MODE_BITS-1:0] in_mode,
  input  ovrq_pkg::dp_sts_t              sts_i,
  output ovrq_pkg::ctrl_cmd_t            cmd_o,
  output logic                           busy
);
  import ovrq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode_t'(in_mode))
            MODE_ADD: begin
              cmd_o.add = 1'b1;
            end
            MODE_POP: begin
              if (sts_i.empty) begin
                cmd_o.pop_fail = 1'b1;
              end else begin
                cmd_o.pop_issue = 1'b1;
                state_nxt       = ST_POP;
              end
            end
            MODE_FIND, MODE_PURGE: begin
              cmd_o.scan_start = 1'b1;
              state_nxt        = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd_o.pop_finish = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.scan_finish = 1'b1;
          state_nxt         = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
